FILE: rtl/core/tcd_pkg.sv
package tcd_pkg;

  // field widths
  localparam int KNOB_BITS = 10;
  localparam int STEPS     = 8;
  localparam int TEMPO_W   = 10;
  localparam int PCT_W     = 7;
  localparam int STEP_W    = 3;
  localparam int GATE_W    = 6;
  localparam int MS_W      = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 10;

  localparam int KNOB_MAX      = (1 << KNOB_BITS) - 1;
  localparam int MS_PER_MINUTE = 60000;
  localparam int PERCENT       = 100;

  // divider sizing: knob * tempo span, or period * percent
  localparam int PROD_KNOB_W = KNOB_BITS + TEMPO_W;
  localparam int PROD_OFF_W  = $clog2(MS_PER_MINUTE * ((1 << PCT_W) - 1) + 1);
  localparam int DVD_W = (PROD_KNOB_W > PROD_OFF_W) ? PROD_KNOB_W : PROD_OFF_W;
  localparam int DVS_W = (KNOB_BITS > TEMPO_W) ? KNOB_BITS : TEMPO_W;
  localparam int DIV_CNT_W = $clog2(DVD_W + 1);

  // shared multiplier operands
  localparam int MUL_A_W = (MS_W > KNOB_BITS) ? MS_W : KNOB_BITS;
  localparam int MUL_B_W = TEMPO_W;
  localparam int MUL_W   = MUL_A_W + MUL_B_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TEMPO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TEMPO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH = 2'd2;

  typedef struct packed {
    logic [TEMPO_W-1:0] min_tempo;
    logic [TEMPO_W-1:0] max_tempo;
    logic [PCT_W-1:0]   max_width_percent;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic                 start;
    logic [KNOB_BITS-1:0] tempo_knob;
    logic [KNOB_BITS-1:0] width_knob;
    cfg_t                 cfg;
  } calc_req_t;

  typedef struct packed {
    logic            busy;
    logic [MS_W-1:0] period_ms;
    logic [MS_W-1:0] off_time_ms;
  } calc_rsp_t;

endpackage

FILE: rtl/core/tcd_in_if.sv
interface tcd_in_if;
  logic                           valid;
  logic                           ready;
  logic [tcd_pkg::KNOB_BITS-1:0]  tempo_knob;
  logic [tcd_pkg::KNOB_BITS-1:0]  width_knob;

  modport source (output valid, output tempo_knob, output width_knob, input ready);
  modport sink (input valid, input tempo_knob, input width_knob, output ready);
endinterface

FILE: rtl/core/tcd_out_if.sv
interface tcd_out_if;
  logic                        valid;
  logic                        ready;
  logic [tcd_pkg::GATE_W-1:0]  gates;
  logic                        beat_led;
  logic [tcd_pkg::STEP_W-1:0]  step_index;

  modport source (output valid, output gates, output beat_led, output step_index,
                  input ready);
  modport sink (input valid, input gates, input beat_led, input step_index,
                output ready);
endinterface

FILE: rtl/core/tcd_cfg_if.sv
interface tcd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tcd_pkg::CFG_IDX_W-1:0]   index;
  logic [tcd_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/tcd_divider.sv
module tcd_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  tcd_pkg::div_req_t req,
  output tcd_pkg::div_rsp_t rsp
);

  logic [tcd_pkg::DVS_W-1:0]     rem_r;
  logic [tcd_pkg::DVD_W-1:0]     dvd_r;
  logic [tcd_pkg::DVS_W-1:0]     dvs_r;
  logic [tcd_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          busy_r;
  logic                          done_r;

  logic [tcd_pkg::DVS_W:0] trial;
  logic [tcd_pkg::DVS_W:0] trial_sub;
  logic                    ge;

  // one restoring step per cycle, quotient bits shift in behind the dividend
  always_comb begin
    trial     = {rem_r, dvd_r[tcd_pkg::DVD_W-1]};
    ge        = (trial >= {1'b0, dvs_r});
    trial_sub = trial - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        rem_r  <= '0;
        dvd_r  <= req.dividend;
        dvs_r  <= req.divisor;
        cnt_r  <= tcd_pkg::DIV_CNT_W'(tcd_pkg::DVD_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? trial_sub[tcd_pkg::DVS_W-1:0] : trial[tcd_pkg::DVS_W-1:0];
        dvd_r <= {dvd_r[tcd_pkg::DVD_W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == tcd_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dvd_r;

endmodule

FILE: rtl/core/tcd_beat_calc.sv
module tcd_beat_calc (
  input  logic               clk,
  input  logic               rst_n,
  input  tcd_pkg::calc_req_t req,
  output tcd_pkg::calc_rsp_t rsp
);

  typedef enum logic [2:0] {
    C_IDLE, C_TMUL, C_TDIV, C_WMUL, C_WDIV, C_PDIV, C_OMUL, C_ODIV
  } calc_state_t;

  calc_state_t state_r;

  logic [tcd_pkg::KNOB_BITS-1:0] tk_r;
  logic [tcd_pkg::KNOB_BITS-1:0] wk_r;
  tcd_pkg::cfg_t                 cfg_r;
  logic [tcd_pkg::TEMPO_W-1:0]   bpm_r;
  logic [tcd_pkg::PCT_W-1:0]     pct_r;
  logic [tcd_pkg::MS_W-1:0]      per_r;
  logic [tcd_pkg::MS_W-1:0]      off_r;

  logic                          div_start_r;
  logic [tcd_pkg::DVD_W-1:0]     div_dvd_r;
  logic [tcd_pkg::DVS_W-1:0]     div_dvs_r;

  tcd_pkg::div_req_t div_req;
  tcd_pkg::div_rsp_t div_rsp;

  logic                          tneg;
  logic [tcd_pkg::TEMPO_W-1:0]   tspan;
  logic                          wneg;
  logic [tcd_pkg::PCT_W-1:0]     wspan;
  logic [tcd_pkg::MUL_A_W-1:0]   mul_a;
  logic [tcd_pkg::MUL_B_W-1:0]   mul_b;
  logic [tcd_pkg::MUL_W-1:0]     mul_p;
  logic [tcd_pkg::TEMPO_W-1:0]   q_t;
  logic [tcd_pkg::PCT_W-1:0]     q_w;
  logic [tcd_pkg::TEMPO_W:0]     bpm_raw;
  logic [tcd_pkg::TEMPO_W-1:0]   bpm_sat;
  logic [tcd_pkg::PCT_W-1:0]     pct_new;
  logic [tcd_pkg::MS_W-1:0]      off_new;

  always_comb begin
    // signed spans handled as magnitude plus a direction flag
    tneg  = (cfg_r.max_tempo < cfg_r.min_tempo);
    tspan = tneg ? (cfg_r.min_tempo - cfg_r.max_tempo)
                 : (cfg_r.max_tempo - cfg_r.min_tempo);
    wneg  = (cfg_r.max_width_percent == '0);
    wspan = wneg ? tcd_pkg::PCT_W'(1) : (cfg_r.max_width_percent - 1'b1);

    unique case (state_r)
      C_TMUL: begin
        mul_a = tcd_pkg::MUL_A_W'(tk_r);
        mul_b = tspan;
      end
      C_WMUL: begin
        mul_a = tcd_pkg::MUL_A_W'(wk_r);
        mul_b = tcd_pkg::MUL_B_W'(wspan);
      end
      default: begin
        mul_a = tcd_pkg::MUL_A_W'(per_r);
        mul_b = tcd_pkg::MUL_B_W'(pct_r);
      end
    endcase
    mul_p = tcd_pkg::MUL_W'(mul_a) * tcd_pkg::MUL_W'(mul_b);

    q_t     = div_rsp.quotient[tcd_pkg::TEMPO_W-1:0];
    q_w     = div_rsp.quotient[tcd_pkg::PCT_W-1:0];
    bpm_raw = tneg ? ({1'b0, cfg_r.min_tempo} - {1'b0, q_t})
                   : ({1'b0, cfg_r.min_tempo} + {1'b0, q_t});
    bpm_sat = (bpm_raw == '0) ? tcd_pkg::TEMPO_W'(1) : bpm_raw[tcd_pkg::TEMPO_W-1:0];
    pct_new = wneg ? (tcd_pkg::PCT_W'(1) - q_w) : (tcd_pkg::PCT_W'(1) + q_w);
    // pulse never outlasts the period
    off_new = (div_rsp.quotient > tcd_pkg::DVD_W'(per_r)) ? per_r
            : div_rsp.quotient[tcd_pkg::MS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= C_IDLE;
      div_start_r <= 1'b0;
      per_r       <= '0;
      off_r       <= '0;
    end else begin
      div_start_r <= 1'b0;
      unique case (state_r)
        C_IDLE: begin
          if (req.start) begin
            tk_r    <= req.tempo_knob;
            wk_r    <= req.width_knob;
            cfg_r   <= req.cfg;
            state_r <= C_TMUL;
          end
        end
        C_TMUL: begin
          div_dvd_r   <= mul_p[tcd_pkg::DVD_W-1:0];
          div_dvs_r   <= tcd_pkg::DVS_W'(tcd_pkg::KNOB_MAX);
          div_start_r <= 1'b1;
          state_r     <= C_TDIV;
        end
        C_TDIV: begin
          if (div_rsp.done) begin
            bpm_r   <= bpm_sat;
            state_r <= C_WMUL;
          end
        end
        C_WMUL: begin
          div_dvd_r   <= mul_p[tcd_pkg::DVD_W-1:0];
          div_dvs_r   <= tcd_pkg::DVS_W'(tcd_pkg::KNOB_MAX);
          div_start_r <= 1'b1;
          state_r     <= C_WDIV;
        end
        C_WDIV: begin
          if (div_rsp.done) begin
            pct_r       <= pct_new;
            div_dvd_r   <= tcd_pkg::DVD_W'(tcd_pkg::MS_PER_MINUTE);
            div_dvs_r   <= tcd_pkg::DVS_W'(bpm_r);
            div_start_r <= 1'b1;
            state_r     <= C_PDIV;
          end
        end
        C_PDIV: begin
          if (div_rsp.done) begin
            per_r   <= div_rsp.quotient[tcd_pkg::MS_W-1:0];
            state_r <= C_OMUL;
          end
        end
        C_OMUL: begin
          div_dvd_r   <= mul_p[tcd_pkg::DVD_W-1:0];
          div_dvs_r   <= tcd_pkg::DVS_W'(tcd_pkg::PERCENT);
          div_start_r <= 1'b1;
          state_r     <= C_ODIV;
        end
        C_ODIV: begin
          if (div_rsp.done) begin
            off_r   <= off_new;
            state_r <= C_IDLE;
          end
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

  assign div_req.start    = div_start_r;
  assign div_req.dividend = div_dvd_r;
  assign div_req.divisor  = div_dvs_r;

  tcd_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign rsp.busy        = (state_r != C_IDLE);
  assign rsp.period_ms   = per_r;
  assign rsp.off_time_ms = off_r;

`ifndef SYNTHESIS
  a_off_within_period: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == C_IDLE) |-> (off_r <= per_r))
    else $error("off time beyond period");

  a_div_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == C_TDIV || state_r == C_WDIV ||
                      state_r == C_PDIV || state_r == C_ODIV))
    else $error("divider result with no division pending");
`endif

endmodule

FILE: rtl/core/tempo_clock_divider_unit.sv
// Tempo clock generator. Each input transaction is one millisecond tick carrying
// the tempo and width knob samples; each tick yields exactly one output
// transaction with the gate levels, the LED level and the current step. A tick
// that does not start a beat is taken once no calculation runs and the output
// slot is free. A tick that starts a beat (the first tick after reset, and
// every tick where the period has run out) samples the knobs and then keeps
// in_ch.ready low while the beat period and pulse length are worked out: four
// divisions on one shared restoring divider with the multiplies between them.
// The output of that tick is offered at once; only the next tick waits.
// Configuration is always ready and is meant to be written between ticks.
module tempo_clock_divider_unit (
  input  logic       clk,
  input  logic       rst_n,
  tcd_in_if.sink     in_ch,
  tcd_out_if.source  out_ch,
  tcd_cfg_if.sink    cfg_ch
);

  tcd_pkg::cfg_t                  cfg_r;
  logic [tcd_pkg::STEP_W-1:0]     step_r;
  logic [tcd_pkg::MS_W-1:0]       elapsed_r;
  logic [tcd_pkg::GATE_W-1:0]     gates_r;
  logic                           led_r;
  logic                           running_r;
  logic                           out_valid_r;

  tcd_pkg::calc_req_t calc_req;
  tcd_pkg::calc_rsp_t calc_rsp;

  logic                           in_acc;
  logic [tcd_pkg::MS_W-1:0]       elapsed_inc;
  logic                           pulse_end;
  logic [tcd_pkg::STEP_W-1:0]     step_adv;
  logic                           beat_start;

  function automatic logic [tcd_pkg::GATE_W-1:0] gate_pattern(
    input logic [tcd_pkg::STEP_W-1:0] step
  );
    logic [tcd_pkg::GATE_W-1:0] pat;
    if (step == '0)            pat = 6'h3F;
    else if (step[0])          pat = 6'h01;
    else if (step[1:0] == '0)  pat = 6'h07;
    else                       pat = 6'h03;
    return pat;
  endfunction

  assign in_ch.ready = !calc_rsp.busy && (!out_valid_r || out_ch.ready);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // tick order: count, end the pulse, then maybe start a beat
  always_comb begin
    elapsed_inc = (running_r && (elapsed_r != '1)) ? (elapsed_r + 1'b1) : elapsed_r;
    pulse_end   = led_r && (elapsed_inc >= calc_rsp.off_time_ms);
    if (!pulse_end)
      step_adv = step_r;
    else if (step_r == tcd_pkg::STEP_W'(tcd_pkg::STEPS - 1))
      step_adv = '0;
    else
      step_adv = step_r + 1'b1;
    beat_start = !running_r || (elapsed_inc >= calc_rsp.period_ms);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_tempo         <= tcd_pkg::TEMPO_W'(60);
      cfg_r.max_tempo         <= tcd_pkg::TEMPO_W'(320);
      cfg_r.max_width_percent <= tcd_pkg::PCT_W'(90);
      step_r      <= '0;
      elapsed_r   <= '0;
      gates_r     <= '0;
      led_r       <= 1'b0;
      running_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          tcd_pkg::CFG_MIN_TEMPO: cfg_r.min_tempo <= cfg_ch.data[tcd_pkg::TEMPO_W-1:0];
          tcd_pkg::CFG_MAX_TEMPO: cfg_r.max_tempo <= cfg_ch.data[tcd_pkg::TEMPO_W-1:0];
          tcd_pkg::CFG_MAX_WIDTH:
            cfg_r.max_width_percent <= cfg_ch.data[tcd_pkg::PCT_W-1:0];
          default: ;
        endcase
      end

      if (in_acc) begin
        step_r      <= step_adv;
        out_valid_r <= 1'b1;
        if (beat_start) begin
          elapsed_r <= '0;
          running_r <= 1'b1;
          led_r     <= 1'b1;
          gates_r   <= gate_pattern(step_adv);
        end else begin
          elapsed_r <= elapsed_inc;
          if (pulse_end) begin
            led_r   <= 1'b0;
            gates_r <= '0;
          end
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign cfg_ch.ready = 1'b1;

  assign calc_req.start      = in_acc && beat_start;
  assign calc_req.tempo_knob = in_ch.tempo_knob;
  assign calc_req.width_knob = in_ch.width_knob;
  assign calc_req.cfg        = cfg_r;

  tcd_beat_calc u_calc (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (calc_req),
    .rsp   (calc_rsp)
  );

  // the state registers only move on a tick, which waits for the output slot
  assign out_ch.valid      = out_valid_r;
  assign out_ch.gates      = gates_r;
  assign out_ch.beat_led   = led_r;
  assign out_ch.step_index = step_r;

`ifndef SYNTHESIS
  a_no_tick_while_calc: assert property (@(posedge clk) disable iff (!rst_n)
    calc_rsp.busy |-> !in_ch.ready)
    else $error("tick taken during beat calculation");

  a_beat_start_raises: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && beat_start) |=> (led_r && running_r && (elapsed_r == '0) && out_valid_r))
    else $error("beat start did not raise the pulse");

  a_gates_track_led: assert property (@(posedge clk) disable iff (!rst_n)
    led_r == (gates_r != '0))
    else $error("gate levels disagree with led");
`endif

endmodule
